[design/jcn_pkg.sv]
// shared types, constants and codes for the joystick conditioner
package jcn_pkg;

  localparam int RAW_W        = 8;
  localparam int RAW_BITS_DEF = 8;
  localparam int CMD_W        = 3;
  localparam int CFG_W        = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int NORM_W       = 16;
  localparam int FRAC_BITS    = 14;
  localparam int QUOT_W       = FRAC_BITS + 1;

  localparam logic [NORM_W-1:0] NORM_MAX = 16'h7FFF;
  localparam logic [NORM_W-1:0] NORM_MIN = 16'h8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE         = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_CENTER = 3'd0,
    CMD_START_CAL  = 3'd1,
    CMD_CALIBRATE  = 3'd2,
    CMD_MEASURE    = 3'd3,
    CMD_STORE_PREV = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_word_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic                     motion;
  } out_word_t;

  // per-axis measure decisions handed from the axis unit to the top
  typedef struct packed {
    logic zero;
    logic sat;
    logic neg;
    logic moved;
  } axis_flags_t;

endpackage

[design/joystick_calibrate_normalize.sv]
// two-axis joystick conditioner: calibration, deadzone, q1.14 normalize, motion
// a measure word runs the 15 steps of the radix-2 divider lanes (one lane per axis,
//   both run together) before it loads the output register; other commands load
//   it directly; no new word is accepted until the last one is loaded
// reset (rst, synchronous): center and previous position zero, extremes empty,
//   deadzone and threshold zero, output register empty
module joystick_calibrate_normalize import jcn_pkg::*; #(
  parameter int RAW_BITS = RAW_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SAMPLE_W = (RAW_BITS < RAW_W) ? RAW_BITS : RAW_W;
  localparam int CNT_W    = $clog2(QUOT_W);
  localparam int DIV_LAT  = QUOT_W + 1;

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    step_cnt;
  logic [CFG_W-1:0]    deadzone;
  logic [CFG_W-1:0]    motion_threshold;
  logic                in_accept;
  logic                is_meas;
  logic                meas;
  logic                div_start;
  logic                div_step;
  logic                out_load;
  axis_flags_t         flags_x;
  axis_flags_t         flags_y;
  axis_flags_t         flags_x_q;
  axis_flags_t         flags_y_q;
  logic [SAMPLE_W-1:0] mag_x;
  logic [SAMPLE_W-1:0] mag_y;
  logic [SAMPLE_W-1:0] span_x;
  logic [SAMPLE_W-1:0] span_y;
  logic [QUOT_W-1:0]   quot_x;
  logic [QUOT_W-1:0]   quot_y;
  out_word_t           out_next;

  function automatic logic [NORM_W-1:0] shape(input axis_flags_t f,
                                              input logic [QUOT_W-1:0] q);
    logic [NORM_W-1:0] mag_q;
    mag_q = NORM_W'(q);
    if (f.zero) begin
      return '0;
    end else if (f.sat) begin
      return f.neg ? NORM_MIN : NORM_MAX;
    end else begin
      return f.neg ? -mag_q : mag_q;
    end
  endfunction

  assign in_accept = in_valid && in_ready;
  assign is_meas   = in_word.command == CMD_MEASURE;
  assign div_start = in_accept && is_meas;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone         <= '0;
      motion_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADZONE:         deadzone         <= cfg_data;
        REG_MOTION_THRESHOLD: motion_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // axis units
  jcn_axis #(.SAMPLE_W(SAMPLE_W)) u_axis_x (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .command          (cmd_t'(in_word.command)),
    .raw              (in_word.raw_x[SAMPLE_W-1:0]),
    .deadzone         (deadzone),
    .motion_threshold (motion_threshold),
    .flags            (flags_x),
    .mag              (mag_x),
    .span             (span_x)
  );

  jcn_axis #(.SAMPLE_W(SAMPLE_W)) u_axis_y (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .command          (cmd_t'(in_word.command)),
    .raw              (in_word.raw_y[SAMPLE_W-1:0]),
    .deadzone         (deadzone),
    .motion_threshold (motion_threshold),
    .flags            (flags_y),
    .mag              (mag_y),
    .span             (span_y)
  );

  // divider lanes
  jcn_div #(.SAMPLE_W(SAMPLE_W)) u_div_x (
    .clk   (clk),
    .start (div_start),
    .step  (div_step),
    .mag   (mag_x),
    .span  (span_x),
    .quot  (quot_x)
  );

  jcn_div #(.SAMPLE_W(SAMPLE_W)) u_div_y (
    .clk   (clk),
    .start (div_start),
    .step  (div_step),
    .mag   (mag_y),
    .span  (span_y),
    .quot  (quot_y)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = is_meas ? ST_DIV : ST_LOAD;
        end
      end
      ST_DIV: begin
        if (step_cnt == CNT_W'(QUOT_W - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV:  div_step = 1'b1;
      ST_LOAD: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (div_start) begin
        step_cnt <= '0;
      end else if (div_step) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  // measure decisions captured with the word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      meas      <= is_meas;
      flags_x_q <= flags_x;
      flags_y_q <= flags_y;
    end
  end

  // result word assembly
  always_comb begin
    out_next.norm_x = meas ? shape(flags_x_q, quot_x) : '0;
    out_next.norm_y = meas ? shape(flags_y_q, quot_y) : '0;
    out_next.motion = meas && (flags_x_q.moved || flags_y_q.moved);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= out_next;
    end
  end

  // measure word reaches the load state after all divider steps
  assert property (@(posedge clk) disable iff (rst)
    div_start |-> ##DIV_LAT (state == ST_LOAD))
    else $error("measure did not reach load after divider steps");

  // other commands skip the divider
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && !is_meas) |=> (state == ST_LOAD))
    else $error("non-measure word did not go straight to load");

  // non-measure words give an all-zero result
  assert property (@(posedge clk) disable iff (rst)
    (out_load && !meas) |=> (out_valid && out_word.norm_x == '0 &&
                             out_word.norm_y == '0 && !out_word.motion))
    else $error("non-measure result not zero");

  // step counter stays within the divider length
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step_cnt <= CNT_W'(QUOT_W - 1)))
    else $error("divider step count out of range");

endmodule

[design/jcn_div.sv]
// bit-serial restoring divider lane producing a q1.14 magnitude
module jcn_div import jcn_pkg::*; #(
  parameter int SAMPLE_W = RAW_BITS_DEF
) (
  input  logic                clk,
  input  logic                start,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] mag,
  input  logic [SAMPLE_W-1:0] span,
  output logic [QUOT_W-1:0]   quot
);

  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] rem_next;
  logic [SAMPLE_W-1:0] div_span;
  logic [QUOT_W-1:0]   shreg;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   diff;
  logic                fits;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, shreg[QUOT_W-1]};
    diff     = trial - {1'b0, div_span};
    fits     = trial >= {1'b0, div_span};
    rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
  end

  // dividend mag * 2^14; its top part mag >> 1 starts below the span unless the axis saturates
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= mag >> 1;
      shreg    <= {mag[0], {FRAC_BITS{1'b0}}};
      div_span <= span;
    end else if (step) begin
      rem      <= rem_next;
      shreg    <= {shreg[QUOT_W-2:0], fits};
    end
  end

  assign quot = shreg;

endmodule

[design/jcn_axis.sv]
// per-axis calibration state and measure setup
module jcn_axis import jcn_pkg::*; #(
  parameter int SAMPLE_W = RAW_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  cmd_t                command,
  input  logic [SAMPLE_W-1:0] raw,
  input  logic [CFG_W-1:0]    deadzone,
  input  logic [CFG_W-1:0]    motion_threshold,
  output axis_flags_t         flags,
  output logic [SAMPLE_W-1:0] mag,
  output logic [SAMPLE_W-1:0] span
);

  logic [SAMPLE_W-1:0] center;
  logic [SAMPLE_W-1:0] low;
  logic [SAMPLE_W-1:0] high;
  logic [SAMPLE_W-1:0] prev;
  logic                low_ok;
  logic                high_ok;

  logic                neg;
  logic [SAMPLE_W:0]   span_sd;
  logic                span_neg;
  logic                ext_ok;
  logic [SAMPLE_W-1:0] dprev;
  logic                low_take;
  logic                high_take;

  // offset, span to the extreme on that side, and motion
  always_comb begin
    neg      = raw < center;
    mag      = neg ? (center - raw) : (raw - center);
    span_sd  = neg ? ({1'b0, center} - {1'b0, low}) : ({1'b0, high} - {1'b0, center});
    span_neg = span_sd[SAMPLE_W];
    span     = span_neg ? SAMPLE_W'(-span_sd) : span_sd[SAMPLE_W-1:0];
    ext_ok   = neg ? low_ok : high_ok;
    dprev    = (raw > prev) ? (raw - prev) : (prev - raw);

    flags.zero  = (mag == '0) || (CFG_W'(mag) < deadzone) || !ext_ok;
    flags.sat   = {1'b0, mag} >= {span, 1'b0};
    flags.neg   = neg ^ span_neg;
    flags.moved = CFG_W'(dprev) > motion_threshold;
  end

  // extremes widen only outward from the center
  always_comb begin
    low_take  = (raw < center) && (!low_ok || (raw < low));
    high_take = (raw > center) && (!high_ok || (raw > high));
  end

  // calibration state update per command
  always_ff @(posedge clk) begin
    if (rst) begin
      center  <= '0;
      prev    <= '0;
      low     <= '1;
      high    <= '0;
      low_ok  <= 1'b0;
      high_ok <= 1'b0;
    end else if (accept) begin
      case (command)
        CMD_SET_CENTER: begin
          center <= raw;
        end
        CMD_START_CAL: begin
          center  <= raw;
          low     <= '1;
          high    <= '0;
          low_ok  <= 1'b0;
          high_ok <= 1'b0;
        end
        CMD_CALIBRATE: begin
          if (low_take) begin
            low    <= raw;
            low_ok <= 1'b1;
          end
          if (high_take) begin
            high    <= raw;
            high_ok <= 1'b1;
          end
        end
        CMD_STORE_PREV: begin
          prev <= raw;
        end
        default: ;
      endcase
    end
  end

endmodule
